FILE: hw/rtl/encoder_trajectory_follower_assert.svh
// Assertion macros for the trajectory follower.
// Included by etf_serial_unit.sv and encoder_trajectory_follower.sv.
`ifndef ENCODER_TRAJECTORY_FOLLOWER_ASSERT_SVH
`define ENCODER_TRAJECTORY_FOLLOWER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define ETF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ETF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ETF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define ETF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/etf_pkg.sv
// Shared types, constants and saturation helpers for the trajectory follower.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package etf_pkg;
  localparam int WORD_W        = 32;
  localparam int TIME_W        = 31;
  localparam int HALF_W        = 16;
  localparam int CFG_IDX_W     = 4;
  localparam int OPND_W        = 33;
  localparam int DIVD_W        = 64;
  localparam int PROD_W        = 66;
  localparam int ACC_W         = 66;
  localparam int STEP_W        = 7;
  localparam int MUL_STEPS     = 33;
  localparam int DIV_STEPS     = 64;
  localparam int COUNT_WIDTH_D = 16;
  localparam int FRAC_BITS_D   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_INIT_POS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TPR      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CIRC     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_V   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_A   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PATH_LEN = 4'd7;

  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_D = 2'd1;
  localparam logic [1:0] TERM_V = 2'd2;
  localparam logic [1:0] TERM_A = 2'd3;

  typedef enum logic {OP_MUL, OP_DIV} etf_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DMUL, S_DDIV, S_ERR, S_DERR, S_RDIV, S_MSTART, S_MUL, S_OUT
  } etf_state_t;

  typedef struct packed {
    logic              start;
    etf_op_t           op;
    logic [DIVD_W-1:0] a;
    logic [OPND_W-1:0] b;
  } etf_unit_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] result;
  } etf_unit_rsp_t;

  // magnitude of a 32-bit signed word
  function automatic logic [OPND_W-1:0] mag32(input logic [WORD_W-1:0] x);
    logic [OPND_W-1:0] e;
    e = {x[WORD_W-1], x};
    return x[WORD_W-1] ? (~e + 33'd1) : e;
  endfunction

  // magnitude of a 33-bit signed word
  function automatic logic [OPND_W-1:0] mag33(input logic [OPND_W-1:0] x);
    return x[OPND_W-1] ? (~x + 33'd1) : x;
  endfunction

  // signed value from sign and magnitude, saturated to 32 bits
  function automatic logic [WORD_W-1:0] sat_mag(input logic neg,
                                                input logic [DIVD_W-1:0] m);
    logic [WORD_W-1:0] r;
    if (!neg) begin
      r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[WORD_W-1:0];
    end else begin
      r = (m > 64'h8000_0000) ? 32'h8000_0000 : (~m[WORD_W-1:0] + 32'd1);
    end
    return r;
  endfunction

  // 33-bit signed to 32 bits, saturated
  function automatic logic [WORD_W-1:0] sat33(input logic [OPND_W-1:0] s);
    logic [WORD_W-1:0] r;
    if (s[32] != s[31]) begin
      r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = s[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] sat_acc(input logic signed [ACC_W-1:0] s);
    logic [WORD_W-1:0] r;
    if (s > $signed(66'sh7FFF_FFFF)) begin
      r = 32'h7FFF_FFFF;
    end else if (s < -$signed(66'sh8000_0000)) begin
      r = 32'h8000_0000;
    end else begin
      r = s[WORD_W-1:0];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/etf_if.sv
// Handshake channels of the trajectory follower: segment input, result, config.
// Depends on etf_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface etf_in_if;
  logic                        valid;
  logic                        ready;
  logic [etf_pkg::WORD_W-1:0]  encoder_count;
  logic [etf_pkg::WORD_W-1:0]  target_position;
  logic [etf_pkg::WORD_W-1:0]  target_velocity;
  logic [etf_pkg::WORD_W-1:0]  target_accel;
  logic [etf_pkg::TIME_W-1:0]  step_time;
  logic [etf_pkg::WORD_W-1:0]  target_heading;
  modport source (output valid, encoder_count, target_position, target_velocity,
                  target_accel, step_time, target_heading, input ready);
  modport sink (input valid, encoder_count, target_position, target_velocity,
                target_accel, step_time, target_heading, output ready);
endinterface

interface etf_out_if;
  logic                        valid;
  logic                        ready;
  logic [etf_pkg::WORD_W-1:0]  drive_value;
  logic [etf_pkg::WORD_W-1:0]  heading_out;
  logic                        done_res;
  logic [etf_pkg::HALF_W-1:0]  segment_index;
  modport source (output valid, drive_value, heading_out, done_res, segment_index,
                  input ready);
  modport sink (input valid, drive_value, heading_out, done_res, segment_index,
                output ready);
endinterface

interface etf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [etf_pkg::CFG_IDX_W-1:0] index;
  logic [etf_pkg::WORD_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/encoder_trajectory_follower.sv
// Top level of the encoder trajectory follower: config registers, sequencer,
// output register. Depends on etf_pkg, etf_if and etf_serial_unit.
`timescale 1ns / 1ps
`default_nettype none
`include "encoder_trajectory_follower_assert.svh"
// One item in, one result out. An item on an active segment runs these steps in
// order, the multiplies and divides in one shared bit-serial multiply/divide unit:
// - The distance multiply, in 33 shift steps.
// - The division by ticks per revolution.
// - Error, then error change.
// - The division by the time step. This is skipped when the step
//   time is zero.
// - Each gain multiply, including its start state. There are four
//   of these, or three when the step time is zero.
// - The output state, then idle to take the next item.
// An item past the end of the path goes from idle straight to the output state.
// One item is processed at a time. The result sits in an output register, so the
// next item is taken while it waits; a second finished item waits in the output
// state until the register frees.
// Config writes are always accepted and must be made while no item is in work.
module encoder_trajectory_follower #(
  parameter int COUNT_WIDTH = etf_pkg::COUNT_WIDTH_D,
  parameter int FRAC_BITS   = etf_pkg::FRAC_BITS_D
) (
  input wire         clk,
  input wire         rst,
  etf_in_if.sink     sample,
  etf_out_if.source  result,
  etf_cfg_if.sink    cfg
);
  import etf_pkg::*;

  // config registers
  logic [WORD_W-1:0] start_count, gain_p, gain_d, gain_v, gain_a;
  logic [HALF_W-1:0] ticks_per_rev, path_length;
  logic [TIME_W-1:0] wheel_circ;

  // follower state
  logic [COUNT_WIDTH-1:0] segment_count;
  logic [WORD_W-1:0]      previous_error, held_heading;
  logic                   finished_flag;

  // per-item work registers
  etf_state_t state, state_next;
  logic [WORD_W-1:0] pos, vel, acc, hdg, travel, err, rate;
  logic [TIME_W-1:0] dt;
  logic              active, neg;
  logic [1:0]        term;
  logic signed [ACC_W-1:0] accum;

  logic out_valid;
  logic [WORD_W-1:0] out_drive, out_heading;
  logic [HALF_W-1:0] out_index;

  etf_unit_req_t req;
  etf_unit_rsp_t rsp;

  etf_serial_unit u_unit (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  logic in_fire, out_free, seg_active;
  logic [OPND_W-1:0] diff, derr;
  logic [WORD_W-1:0] tx, tg, dterm;
  logic signed [PROD_W-1:0] prod;
  logic [31:0] cnt_ext;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [31:0] inc_ext;

  assign cfg.ready    = 1'b1;
  assign sample.ready = (state == S_IDLE);
  assign in_fire      = sample.valid && sample.ready;
  assign out_free     = !out_valid || result.ready;
  assign cnt_ext      = 32'(segment_count);
  assign cnt_inc      = segment_count + COUNT_WIDTH'(1);  // wraps at COUNT_WIDTH
  assign inc_ext      = 32'(cnt_inc);
  assign seg_active   = cnt_ext < 32'(path_length);

  always_comb begin
    diff  = {sample.encoder_count[WORD_W-1], sample.encoder_count}
          - {start_count[WORD_W-1], start_count};
    derr  = {err[WORD_W-1], err} - {previous_error[WORD_W-1], previous_error};
    // derivative term when the step time is zero
    if (gain_d == '0 || derr == '0) begin
      dterm = '0;
    end else if (gain_d[WORD_W-1] == derr[OPND_W-1]) begin
      dterm = 32'h7FFF_FFFF;
    end else begin
      dterm = 32'h8000_0000;
    end
    case (term)
      TERM_P:  begin tx = err;  tg = gain_p; end
      TERM_D:  begin tx = rate; tg = gain_d; end
      TERM_V:  begin tx = vel;  tg = gain_v; end
      TERM_A:  begin tx = acc;  tg = gain_a; end
      default: begin tx = err;  tg = gain_p; end
    endcase
    prod = neg ? -$signed(rsp.result) : $signed(rsp.result);
  end

  // sequencer: next state and unit requests
  always_comb begin
    state_next = state;
    req.start  = 1'b0;
    req.op     = OP_MUL;
    req.a      = '0;
    req.b      = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (seg_active) begin
            req.start  = 1'b1;
            req.a      = DIVD_W'(mag33(diff));
            req.b      = OPND_W'(wheel_circ);
            state_next = S_DMUL;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_DMUL: begin
        if (rsp.done) begin
          req.start  = 1'b1;
          req.op     = OP_DIV;
          req.a      = rsp.result[DIVD_W-1:0];
          req.b      = (ticks_per_rev == '0) ? OPND_W'(1) : OPND_W'(ticks_per_rev);
          state_next = S_DDIV;
        end
      end
      S_DDIV: if (rsp.done) state_next = S_ERR;
      S_ERR:  state_next = S_DERR;
      S_DERR: begin
        if (dt == '0) begin
          state_next = S_MSTART;
        end else begin
          req.start  = 1'b1;
          req.op     = OP_DIV;
          req.a      = DIVD_W'(mag33(derr)) << FRAC_BITS;
          req.b      = OPND_W'(dt);
          state_next = S_RDIV;
        end
      end
      S_RDIV: if (rsp.done) state_next = S_MSTART;
      S_MSTART: begin
        req.start  = 1'b1;
        req.a      = DIVD_W'(mag32(tx));
        req.b      = mag32(tg);
        state_next = S_MUL;
      end
      S_MUL: begin
        if (rsp.done) state_next = (term == TERM_A) ? S_OUT : S_MSTART;
      end
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_count   <= '0;
      ticks_per_rev <= HALF_W'(1);
      wheel_circ    <= TIME_W'(65536);
      gain_p        <= '0;
      gain_d        <= '0;
      gain_v        <= '0;
      gain_a        <= '0;
      path_length   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_INIT_POS: start_count   <= cfg.data;
        REG_TPR:      ticks_per_rev <= cfg.data[HALF_W-1:0];
        REG_CIRC:     wheel_circ    <= cfg.data[TIME_W-1:0];
        REG_GAIN_P:   gain_p        <= cfg.data;
        REG_GAIN_D:   gain_d        <= cfg.data;
        REG_GAIN_V:   gain_v        <= cfg.data;
        REG_GAIN_A:   gain_a        <= cfg.data;
        REG_PATH_LEN: path_length   <= cfg.data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath registers and follower state
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count  <= '0;
      previous_error <= '0;
      held_heading   <= '0;
      finished_flag  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            pos    <= sample.target_position;
            vel    <= sample.target_velocity;
            acc    <= sample.target_accel;
            dt     <= sample.step_time;
            hdg    <= sample.target_heading;
            active <= seg_active;
            neg    <= diff[OPND_W-1];
            accum  <= '0;
            term   <= TERM_P;
          end
        end
        S_DDIV: if (rsp.done) travel <= sat_mag(neg, rsp.result[DIVD_W-1:0]);
        S_ERR:  err <= sat33({pos[WORD_W-1], pos} - {travel[WORD_W-1], travel});
        S_DERR: begin
          neg <= derr[OPND_W-1];
          if (dt == '0) accum <= ACC_W'($signed(dterm));
        end
        S_RDIV: if (rsp.done) rate <= sat_mag(neg, rsp.result[DIVD_W-1:0]);
        S_MSTART: neg <= tx[WORD_W-1] ^ tg[WORD_W-1];
        S_MUL: begin
          if (rsp.done) begin
            accum <= accum + ACC_W'(prod >>> FRAC_BITS);
            // the derivative product is skipped when it came from the zero-dt rule
            if (term == TERM_P && dt == '0) term <= TERM_V;
            else term <= term + 2'd1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            if (active) begin
              out_drive      <= sat_acc(accum);
              out_heading    <= hdg;
              out_index      <= inc_ext[HALF_W-1:0];
              finished_flag  <= 1'b0;
              previous_error <= err;
              held_heading   <= hdg;
              segment_count  <= cnt_inc;
            end else begin
              out_drive     <= '0;
              out_heading   <= held_heading;
              out_index     <= cnt_ext[HALF_W-1:0];
              finished_flag <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign result.valid         = out_valid;
  assign result.drive_value   = out_drive;
  assign result.heading_out   = out_heading;
  assign result.done_res      = finished_flag;
  assign result.segment_index = out_index;

  `ETF_ASSERT_NOW(a_unit_idle, clk, rst, state == S_IDLE, !rsp.busy, "unit busy in idle")
  `ETF_ASSERT_NEXT(a_take_leaves_idle, clk, rst, in_fire, state != S_IDLE, "item lost")
  `ETF_ASSERT_NOW(a_done_zero, clk, rst, out_valid && finished_flag, out_drive == '0, "finished result with nonzero drive")
endmodule
`default_nettype wire

FILE: hw/rtl/etf_serial_unit.sv
// Bit-serial unsigned multiplier and restoring divider, one bit per cycle.
// Depends on etf_pkg and encoder_trajectory_follower_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "encoder_trajectory_follower_assert.svh"
module etf_serial_unit (
  input  wire                    clk,
  input  wire                    rst,
  input  etf_pkg::etf_unit_req_t req,
  output etf_pkg::etf_unit_rsp_t rsp
);
  import etf_pkg::*;

  logic [PROD_W-1:0] work;
  logic [OPND_W-1:0] rem;
  logic [OPND_W-1:0] divisor;
  logic [STEP_W-1:0] steps;
  etf_op_t           op;
  logic              busy;
  logic              done;

  logic [OPND_W:0]   msum;
  logic [OPND_W-1:0] trial;
  logic              fits;

  always_comb begin
    msum  = {1'b0, work[PROD_W-1:OPND_W]} + (work[0] ? {1'b0, divisor} : 34'd0);
    trial = {rem[OPND_W-2:0], work[DIVD_W-1]};
    fits  = trial >= divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        op      <= req.op;
        divisor <= req.b;
        rem     <= '0;
        if (req.op == OP_MUL) begin
          work  <= {33'd0, req.a[OPND_W-1:0]};
          steps <= STEP_W'(MUL_STEPS);
        end else begin
          work  <= {2'b00, req.a};
          steps <= STEP_W'(DIV_STEPS);
        end
      end else if (busy) begin
        if (op == OP_MUL) begin
          work <= {msum, work[OPND_W-1:1]};
        end else begin
          rem  <= fits ? (trial - divisor) : trial;
          work <= {2'b00, work[DIVD_W-2:0], fits};
        end
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy   = busy;
  assign rsp.done   = done;
  assign rsp.result = work;

  `ETF_ASSERT_NOW(a_no_restart, clk, rst, req.start, !busy, "start while busy")
  `ETF_ASSERT_NOW(a_done_after_busy, clk, rst, done, $past(busy), "done without run")
  `ETF_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "done while still busy")
endmodule
`default_nettype wire

FILE: tb/tb_encoder_trajectory_follower.sv
// Self-checking bench for encoder_trajectory_follower: predicts each result
// from the configured gains and path, compares every output field.
// Depends on etf_pkg, etf_if and the RTL of the follower.
`timescale 1ns / 1ps
module tb_encoder_trajectory_follower;
  import etf_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int CYC_LIMIT  = 1500000;
  localparam int DRAIN_CYC  = 400;

  typedef struct packed {
    logic [31:0] enc;
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] acc;
    logic [30:0] dt;
    logic [31:0] hdg;
  } segment_t;

  typedef struct packed {
    logic [31:0] drive;
    logic [31:0] heading;
    logic        done;
    logic [15:0] index;
  } drive_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #(CLK_HALF) clk = ~clk;

  etf_in_if  seg_ch ();
  etf_out_if res_ch ();
  etf_cfg_if cfg_ch ();

  encoder_trajectory_follower u_dut (
    .clk(clk), .rst(rst), .sample(seg_ch.sink), .result(res_ch.source), .cfg(cfg_ch.sink)
  );

  // predictor copy of registers and state
  logic signed [31:0] p_init, p_kp, p_kd, p_kv, p_ka;
  logic [15:0] p_tpr, p_len, p_count;
  logic [30:0] p_circ;
  logic signed [31:0] p_prev_err, p_held_hdg;
  logic p_finished;

  segment_t   seg_pending[$];
  drive_res_t drive_expected[$];
  int errors = 0;
  int n_results = 0;
  int n_done_results = 0;
  longint cycle = 0;

  // pressure controls
  bit hold_sink = 1'b0;
  bit sink_stall_mode = 1'b0;

  function automatic logic signed [63:0] sat_word(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 64'sd2147483647;
    if (v < -128'sd2147483648) return -64'sd2147483648;
    return v[63:0];
  endfunction

  // gain*value >> 16, floor
  function automatic logic signed [127:0] qmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [127:0] pr;
    pr = 128'(a) * 128'(b);
    return pr >>> 16;
  endfunction

  function automatic drive_res_t follow_step(input segment_t s);
    drive_res_t r;
    logic signed [127:0] diff, travel, err, derr, rate, dterm, sum;
    logic signed [127:0] tpr, dtv;
    logic signed [63:0] drv;
    int sg;
    r = '0;
    if (p_count < p_len) begin
      tpr  = (p_tpr == 0) ? 128'sd1 : $signed(128'(p_tpr));
      diff = 128'($signed(s.enc)) - 128'(p_init);
      travel = sat_word((diff * $signed(128'(p_circ))) / tpr);
      err  = sat_word(128'($signed(s.pos)) - travel);
      derr = err - 128'(p_prev_err);
      dtv  = $signed(128'(s.dt));
      if (s.dt == 0) begin
        sg = ((p_kd > 0) - (p_kd < 0)) * ((derr > 0) - (derr < 0));
        dterm = sg > 0 ? 128'sd2147483647 : (sg < 0 ? -128'sd2147483648 : 128'sd0);
      end else begin
        rate  = sat_word((derr * 128'sd65536) / dtv);
        dterm = qmul(64'(p_kd), rate[63:0]);
      end
      sum = qmul(64'(p_kp), err[63:0]) + dterm + qmul(64'(p_kv), 64'($signed(s.vel)))
          + qmul(64'(p_ka), 64'($signed(s.acc)));
      drv = sat_word(sum);
      r.drive = drv[31:0];
      p_finished = 1'b0;
      p_prev_err = err[31:0];
      p_held_hdg = s.hdg;
      p_count = p_count + 16'd1;
      r.heading = s.hdg;
    end else begin
      p_finished = 1'b1;
      r.heading = p_held_hdg;
    end
    r.done = p_finished;
    r.index = p_count;
    return r;
  endfunction

  // driver: bursts and gaps; the front of seg_pending is the item on offer
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst) begin
      seg_ch.valid <= 1'b0;
    end else begin
      if (seg_ch.valid && seg_ch.ready) begin
        drive_expected.push_back(follow_step(seg_pending.pop_front()));
      end
      if (seg_ch.valid && !seg_ch.ready) begin
        // keep offering
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        seg_ch.valid <= 1'b0;
      end else if (seg_pending.size() > 0) begin
        segment_t nx;
        nx = seg_pending[0];
        seg_ch.valid <= 1'b1;
        {seg_ch.encoder_count, seg_ch.target_position, seg_ch.target_velocity,
         seg_ch.target_accel, seg_ch.step_time, seg_ch.target_heading} <= nx;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        seg_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and sink stall pattern
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        drive_res_t got, exp_r;
        got = {res_ch.drive_value, res_ch.heading_out, res_ch.done_res,
               res_ch.segment_index};
        n_results++;
        if (got.done) n_done_results++;
        if (drive_expected.size() == 0) begin
          $error("result with nothing expected: drive=%h", got.drive);
          errors++;
        end else begin
          exp_r = drive_expected.pop_front();
          if (got.drive !== exp_r.drive) begin
            $error("drive_value exp %h got %h", exp_r.drive, got.drive); errors++;
          end
          if (got.heading !== exp_r.heading) begin
            $error("heading_out exp %h got %h", exp_r.heading, got.heading); errors++;
          end
          if (got.done !== exp_r.done) begin
            $error("done_res exp %b got %b", exp_r.done, got.done); errors++;
          end
          if (got.index !== exp_r.index) begin
            $error("segment_index exp %h got %h", exp_r.index, got.index); errors++;
          end
        end
      end
      if (hold_sink) res_ch.ready <= 1'b0;
      else if (sink_stall_mode) res_ch.ready <= ($urandom_range(0, 3) != 0);
      else res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (cycle > CYC_LIMIT) begin
      $display("timeout at cycle %0d", cycle);
      $display("** encoder_trajectory_follower: FAILED **");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_INIT_POS: p_init = val;
      REG_TPR:      p_tpr  = val[15:0];
      REG_CIRC:     p_circ = val[30:0];
      REG_GAIN_P:   p_kp   = val;
      REG_GAIN_D:   p_kd   = val;
      REG_GAIN_V:   p_kv   = val;
      REG_GAIN_A:   p_ka   = val;
      REG_PATH_LEN: p_len  = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (seg_pending.size() != 0 || seg_ch.valid || drive_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 255) - 128;
      3: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic segment_t rnd_segment();
    segment_t s;
    s.enc = rnd_word();
    s.pos = rnd_word();
    s.vel = rnd_word();
    s.acc = rnd_word();
    case ($urandom_range(0, 5))
      0: s.dt = '0;
      1: s.dt = 31'h7FFF_FFFF;
      2: s.dt = 31'($urandom_range(1, 32'h2_0000));
      default: s.dt = 31'($urandom);
    endcase
    s.hdg = $urandom;
    return s;
  endfunction

  // random register setting; extremes often
  task automatic cfg_random(input int plen);
    cfg_write(REG_INIT_POS, rnd_word());
    cfg_write(REG_TPR, ($urandom_range(0, 4) == 0) ? 32'($urandom_range(0, 1) * 65535)
                                                    : $urandom_range(1, 4096));
    cfg_write(REG_CIRC, ($urandom_range(0, 4) == 0) ? 32'h7FFF_FFFF
                                                     : $urandom_range(0, 32'h8_0000));
    cfg_write(REG_GAIN_P, rnd_word());
    cfg_write(REG_GAIN_D, rnd_word());
    cfg_write(REG_GAIN_V, rnd_word());
    cfg_write(REG_GAIN_A, rnd_word());
    cfg_write(REG_PATH_LEN, plen);
  endtask

  initial begin
    segment_t s;
    seg_ch.valid = 1'b0;
    seg_ch.encoder_count = '0; seg_ch.target_position = '0; seg_ch.target_velocity = '0;
    seg_ch.target_accel = '0; seg_ch.step_time = '0; seg_ch.target_heading = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    p_init = 0; p_tpr = 1; p_circ = 31'd65536; p_kp = 0; p_kd = 0; p_kv = 0; p_ka = 0;
    p_len = 0; p_count = 0; p_prev_err = 0; p_held_hdg = 0; p_finished = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // finished before any segment: zero drive, zero heading held
    s = '0; s.hdg = 32'h1234_5678; seg_pending.push_back(s);
    wait_idle();

    // directed: extremes, zero dt both signs, zero tpr
    cfg_write(REG_INIT_POS, 32'h8000_0000);
    cfg_write(REG_TPR, 32'd0);
    cfg_write(REG_CIRC, 32'h7FFF_FFFF);
    cfg_write(REG_GAIN_P, 32'h7FFF_FFFF);
    cfg_write(REG_GAIN_D, 32'h8000_0000);
    cfg_write(REG_GAIN_V, 32'h0001_0000);
    cfg_write(REG_GAIN_A, 32'hFFFF_0000);
    cfg_write(REG_PATH_LEN, 32'd12);
    s = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0, 32'h7FFF_FFFF};
    seg_pending.push_back(s);
    s = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 32'h8000_0000};
    seg_pending.push_back(s);
    s = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 31'd0, 32'h0};  // no error change
    seg_pending.push_back(s);
    s = '{32'h0, 32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF, 32'hFFFF_FFFF};
    seg_pending.push_back(s);
    s = '{32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF, 31'd1, 32'h5555_5555};
    seg_pending.push_back(s);
    s = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAA,
          32'hAAAA_AAAA};
    seg_pending.push_back(s);
    for (int i = 0; i < 8; i++) seg_pending.push_back(rnd_segment());  // runs past end
    wait_idle();
    // longer path resumes, then gain_d positive with zero dt
    cfg_write(REG_GAIN_D, 32'h7FFF_FFFF);
    cfg_write(REG_TPR, 32'd65535);
    cfg_write(REG_PATH_LEN, 32'd16);
    s = '{32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 31'd0, 32'h1};
    seg_pending.push_back(s);
    s = '{32'h0, 32'h8000_0000, 32'h0, 32'h0, 31'd0, 32'h2};
    seg_pending.push_back(s);
    wait_idle();

    // random phases; path short enough to see finished often
    sink_stall_mode = 1'b1;
    for (int ph = 0; ph < 12; ph++) begin
      cfg_random(p_count + $urandom_range(0, 60));
      if (ph == 3) begin
        // long receiver hold while segments keep coming
        fork
          begin
            hold_sink = 1'b1;
            repeat (3000) @(posedge clk);
            hold_sink = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < 52; i++) seg_pending.push_back(rnd_segment());
      if (ph == 6) sink_stall_mode = 1'b0;
      if (ph == 9) sink_stall_mode = 1'b1;
      wait_idle();  // sender pauses until all results are back
    end
    // path length at its 16-bit maximum
    cfg_write(REG_PATH_LEN, 32'hFFFF);
    p_count = p_count;  // device count unchanged; wrap needs many segments
    for (int i = 0; i < 6; i++) seg_pending.push_back(rnd_segment());
    wait_idle();

    $display("covered %0d results (%0d past path end) over 12 random settings",
             n_results, n_done_results);
    if (errors == 0) $display("** encoder_trajectory_follower: PASSED **");
    else $display("** encoder_trajectory_follower: FAILED **");
    $finish;
  end
endmodule
